FILE: src/hdu_pkg.sv
// Shared types, constants and lookup functions for the HTTP date converter.
// Depends on nothing; every other file of the block imports it.
package hdu_pkg;

   // One input word: a string byte and its end marker.
   typedef struct packed {
      logic [7:0] char_byte;
      logic       is_last;
   } req_type;

   // One result word: the verdict and the converted time.
   typedef struct packed {
      logic        date_valid;
      logic [37:0] unix_seconds;
   } rsp_type;

   // A parsed date handed from the parser to the converter.
   typedef struct packed {
      logic        ok;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [13:0] year;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
   } job_type;

   localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;

   localparam logic [21:0] EPOCH_SHIFT     = 22'd719468;
   localparam logic [16:0] SECONDS_PER_DAY = 17'd86400;
   localparam logic [16:0] SECONDS_PER_HR  = 17'd3600;
   localparam logic [13:0] EPOCH_YEAR      = 14'd1970;
   localparam logic [21:0] DAYS_PER_YEAR   = 22'd365;
   // Reciprocal of 25 scaled by two to the seventeenth power.
   localparam logic [12:0] RECIP_25        = 13'd5243;
   localparam int unsigned RECIP_SHIFT     = 17;

   // Three lower-case letters of each month name, first letter in the top byte.
   function automatic logic [23:0] month_name(input logic [3:0] m);
      logic [23:0] name;
      unique case (m)
         4'd0:    name = "jan";
         4'd1:    name = "feb";
         4'd2:    name = "mar";
         4'd3:    name = "apr";
         4'd4:    name = "may";
         4'd5:    name = "jun";
         4'd6:    name = "jul";
         4'd7:    name = "aug";
         4'd8:    name = "sep";
         4'd9:    name = "oct";
         4'd10:   name = "nov";
         4'd11:   name = "dec";
         default: name = 24'h0;
      endcase
      return name;
   endfunction

   // The two accepted zone names: an input of 0 is GMT, 1 is UTC.
   function automatic logic [23:0] zone_name(input logic z);
      return z ? 24'("utc") : 24'("gmt");
   endfunction

   // Day of the March-based year on which each month starts (January is 0).
   function automatic logic [8:0] month_offset(input logic [3:0] m);
      logic [8:0] off;
      unique case (m)
         4'd0:    off = 9'd306;
         4'd1:    off = 9'd337;
         4'd2:    off = 9'd0;
         4'd3:    off = 9'd31;
         4'd4:    off = 9'd61;
         4'd5:    off = 9'd92;
         4'd6:    off = 9'd122;
         4'd7:    off = 9'd153;
         4'd8:    off = 9'd184;
         4'd9:    off = 9'd214;
         4'd10:   off = 9'd245;
         4'd11:   off = 9'd275;
         default: off = 9'd0;
      endcase
      return off;
   endfunction

   // Upper-case ASCII letters fold to lower case; all other bytes pass.
   function automatic logic [7:0] to_lower(input logic [7:0] c);
      return (c >= 8'h41 && c <= 8'h5A) ? 8'(c + 8'd32) : c;
   endfunction

endpackage

FILE: src/hdu_parser.sv
// Front end: walks the date string one byte per word and classifies it.
// On the final byte it pushes a parsed date into the job queue. Uses hdu_pkg.
module hdu_parser (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  hdu_pkg::req_type req_data,
   output logic             job_push,
   input  logic             job_full,
   output hdu_pkg::job_type job_data
);
   import hdu_pkg::*;

   // Positions within the fixed date form.
   localparam logic [4:0] PH_WDAY0  = 5'd0;
   localparam logic [4:0] PH_WDAY1  = 5'd1;
   localparam logic [4:0] PH_WDAY2  = 5'd2;
   localparam logic [4:0] PH_COMMA  = 5'd3;
   localparam logic [4:0] PH_SKIP   = 5'd4;
   localparam logic [4:0] PH_DAY0   = 5'd5;
   localparam logic [4:0] PH_DAY1   = 5'd6;
   localparam logic [4:0] PH_SP0    = 5'd7;
   localparam logic [4:0] PH_MON0   = 5'd8;
   localparam logic [4:0] PH_MON1   = 5'd9;
   localparam logic [4:0] PH_MON2   = 5'd10;
   localparam logic [4:0] PH_SP1    = 5'd11;
   localparam logic [4:0] PH_YEAR0  = 5'd12;
   localparam logic [4:0] PH_YEAR1  = 5'd13;
   localparam logic [4:0] PH_YEAR2  = 5'd14;
   localparam logic [4:0] PH_YEAR3  = 5'd15;
   localparam logic [4:0] PH_SP2    = 5'd16;
   localparam logic [4:0] PH_HOUR0  = 5'd17;
   localparam logic [4:0] PH_HOUR1  = 5'd18;
   localparam logic [4:0] PH_COLON0 = 5'd19;
   localparam logic [4:0] PH_MIN0   = 5'd20;
   localparam logic [4:0] PH_MIN1   = 5'd21;
   localparam logic [4:0] PH_COLON1 = 5'd22;
   localparam logic [4:0] PH_SEC0   = 5'd23;
   localparam logic [4:0] PH_SEC1   = 5'd24;
   localparam logic [4:0] PH_ZONE   = 5'd25;

   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_NUL   = 8'h00;

   logic [4:0]  phase_ff, phase_in, phase_nx;
   logic [2:0]  zcount_ff, zcount_in, zcount_nx;
   logic [6:0]  day_ff, day_in, day_nx;
   logic [11:0] mcand_ff, mcand_in, mcand_nx;
   logic [13:0] year_ff, year_in, year_nx;
   logic [6:0]  hour_ff, hour_in, hour_nx;
   logic [6:0]  min_ff, min_in, min_nx;
   logic [6:0]  sec_ff, sec_in, sec_nx;
   logic [1:0]  zcand_ff, zcand_in, zcand_nx;
   logic        failed_ff, failed_in, failed_nx;
   logic        matched_ff, matched_in, matched_nx;

   logic        accept;
   logic [7:0]  c;
   logic [7:0]  lc;
   logic [7:0]  digit;
   logic        is_dig;
   logic        advance;
   logic [1:0]  mk;
   logic [1:0]  zk;
   logic [3:0]  mon_idx;
   logic        date_ok;
   logic [23:0] mname;
   logic [23:0] zname;

   // A new word is refused only while the job queue has no room.
   assign req_full = job_full;
   assign accept   = req_push && !job_full;

   assign c      = req_data.char_byte;
   assign lc     = to_lower(c);
   assign is_dig = (c >= CH_ZERO) && (c <= CH_NINE);
   assign digit  = 8'(c - CH_ZERO);
   assign mk     = 2'(phase_ff - PH_MON0);
   assign zk     = zcount_ff[1:0];

   // Effect of one byte on the parse state.
   always_comb begin
      phase_nx   = phase_ff;
      zcount_nx  = zcount_ff;
      day_nx     = day_ff;
      mcand_nx   = mcand_ff;
      year_nx    = year_ff;
      hour_nx    = hour_ff;
      min_nx     = min_ff;
      sec_nx     = sec_ff;
      zcand_nx   = zcand_ff;
      failed_nx  = failed_ff;
      matched_nx = matched_ff;
      advance    = 1'b1;
      mname      = 24'h0;
      zname      = 24'h0;
      if (failed_ff || matched_ff) begin
         advance = 1'b0;
      end else if (c == CH_NUL) begin
         failed_nx = 1'b1;
      end else begin
         unique case (phase_ff)
            PH_WDAY0, PH_WDAY1, PH_WDAY2: begin
               if (c == CH_COMMA) failed_nx = 1'b1;
            end
            PH_COMMA: begin
               if (c != CH_COMMA) failed_nx = 1'b1;
            end
            PH_SKIP: begin
            end
            PH_DAY0, PH_DAY1: begin
               if (is_dig) day_nx = 7'(day_ff * 7'd10 + digit[6:0]);
               else failed_nx = 1'b1;
            end
            PH_SP0, PH_SP1, PH_SP2: begin
               if (c != CH_SPACE) failed_nx = 1'b1;
            end
            PH_MON0, PH_MON1, PH_MON2: begin
               for (int m = 0; m < 12; m++) begin
                  mname = month_name(4'(m));
                  if (mname[23 - 8 * mk -: 8] != lc) mcand_nx[m] = 1'b0;
               end
               if (mcand_nx == 12'd0) failed_nx = 1'b1;
            end
            PH_YEAR0, PH_YEAR1, PH_YEAR2, PH_YEAR3: begin
               if (is_dig) year_nx = 14'(year_ff * 14'd10 + 14'(digit));
               else failed_nx = 1'b1;
            end
            PH_HOUR0, PH_HOUR1: begin
               if (is_dig) hour_nx = 7'(hour_ff * 7'd10 + digit[6:0]);
               else failed_nx = 1'b1;
            end
            PH_COLON0, PH_COLON1: begin
               if (c != CH_COLON) failed_nx = 1'b1;
            end
            PH_MIN0, PH_MIN1: begin
               if (is_dig) min_nx = 7'(min_ff * 7'd10 + digit[6:0]);
               else failed_nx = 1'b1;
            end
            PH_SEC0, PH_SEC1: begin
               if (is_dig) sec_nx = 7'(sec_ff * 7'd10 + digit[6:0]);
               else failed_nx = 1'b1;
            end
            default: begin
               // Zone name, after any number of leading spaces.
               advance = 1'b0;
               if (zcount_ff == 3'd0 && c == CH_SPACE) begin
               end else if (zcount_ff > 3'd2) begin
                  failed_nx = 1'b1;
               end else begin
                  for (int z = 0; z < 2; z++) begin
                     zname = zone_name(z[0]);
                     if (zname[23 - 8 * zk -: 8] != lc) zcand_nx[z] = 1'b0;
                  end
                  if (zcand_nx == 2'd0) begin
                     failed_nx = 1'b1;
                  end else begin
                     zcount_nx = 3'(zcount_ff + 3'd1);
                     if (zcount_ff == 3'd2) matched_nx = 1'b1;
                  end
               end
            end
         endcase
         if (advance && !failed_nx && phase_ff < PH_ZONE) phase_nx = 5'(phase_ff + 5'd1);
      end
   end

   // Month number is the lowest surviving candidate, December by default.
   always_comb begin
      mon_idx = 4'd11;
      for (int m = 10; m >= 0; m--) begin
         if (mcand_nx[m]) mon_idx = 4'(m);
      end
   end

   // Form and range checks for the verdict on the final byte.
   assign date_ok = matched_nx && !failed_nx && (mcand_nx != 12'd0) &&
                    (day_nx >= 7'd1) && (day_nx <= 7'd31) && (hour_nx <= 7'd23) &&
                    (min_nx <= 7'd59) && (sec_nx <= 7'd60) && (year_nx >= EPOCH_YEAR);

   assign job_push        = accept && req_data.is_last;
   assign job_data.ok     = date_ok;
   assign job_data.month  = mon_idx;
   assign job_data.day    = day_nx[4:0];
   assign job_data.year   = year_nx;
   assign job_data.hour   = hour_nx[4:0];
   assign job_data.minute = min_nx[5:0];
   assign job_data.second = sec_nx[5:0];

   // Take the parsed state, or start afresh once a verdict is out.
   always_comb begin
      phase_in   = phase_ff;
      zcount_in  = zcount_ff;
      day_in     = day_ff;
      mcand_in   = mcand_ff;
      year_in    = year_ff;
      hour_in    = hour_ff;
      min_in     = min_ff;
      sec_in     = sec_ff;
      zcand_in   = zcand_ff;
      failed_in  = failed_ff;
      matched_in = matched_ff;
      if (accept && req_data.is_last) begin
         phase_in   = PH_WDAY0;
         zcount_in  = 3'd0;
         day_in     = 7'd0;
         mcand_in   = 12'hFFF;
         year_in    = 14'd0;
         hour_in    = 7'd0;
         min_in     = 7'd0;
         sec_in     = 7'd0;
         zcand_in   = 2'b11;
         failed_in  = 1'b0;
         matched_in = 1'b0;
      end else if (accept) begin
         phase_in   = phase_nx;
         zcount_in  = zcount_nx;
         day_in     = day_nx;
         mcand_in   = mcand_nx;
         year_in    = year_nx;
         hour_in    = hour_nx;
         min_in     = min_nx;
         sec_in     = sec_nx;
         zcand_in   = zcand_nx;
         failed_in  = failed_nx;
         matched_in = matched_nx;
      end
   end

   // Parse state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_WDAY0;
         zcount_ff  <= 3'd0;
         day_ff     <= 7'd0;
         mcand_ff   <= 12'hFFF;
         year_ff    <= 14'd0;
         hour_ff    <= 7'd0;
         min_ff     <= 7'd0;
         sec_ff     <= 7'd0;
         zcand_ff   <= 2'b11;
         failed_ff  <= 1'b0;
         matched_ff <= 1'b0;
      end else begin
         phase_ff   <= phase_in;
         zcount_ff  <= zcount_in;
         day_ff     <= day_in;
         mcand_ff   <= mcand_in;
         year_ff    <= year_in;
         hour_ff    <= hour_in;
         min_ff     <= min_in;
         sec_ff     <= sec_in;
         zcand_ff   <= zcand_in;
         failed_ff  <= failed_in;
         matched_ff <= matched_in;
      end
   end

endmodule

FILE: src/hdu_queue.sv
// Short first-in first-out queue of parsed dates between parser and converter.
// Uses hdu_pkg for the job word type.
module hdu_queue #(
   parameter int unsigned DEPTH = hdu_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  hdu_pkg::job_type push_data,
   input  logic             pop,
   output logic             empty,
   output hdu_pkg::job_type pop_data
);
   import hdu_pkg::*;

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   job_type          store [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full     = (count_ff == FULL_CNT);
   assign empty    = (count_ff == CNT_W'(0));
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = store[rd_ptr_ff];

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? PTR_W'(0) : PTR_W'(wr_ptr_ff + 1'b1);
      if (do_pop)  rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? PTR_W'(0) : PTR_W'(rd_ptr_ff + 1'b1);
      if (do_push && !do_pop) count_in = CNT_W'(count_ff + 1'b1);
      else if (do_pop && !do_push) count_in = CNT_W'(count_ff - 1'b1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= PTR_W'(0);
         rd_ptr_ff <= PTR_W'(0);
         count_ff  <= CNT_W'(0);
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage; holds payload only, so it needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) store[wr_ptr_ff] <= push_data;
   end

endmodule

FILE: src/hdu_convert.sv
// Back end: turns a parsed date into Unix seconds over four steps and holds
// the result in an output register until it is taken. Uses hdu_pkg.
module hdu_convert (
   input  logic             clock,
   input  logic             reset,
   input  logic             job_empty,
   output logic             job_pop,
   input  hdu_pkg::job_type job_data,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output hdu_pkg::rsp_type rsp_data
);
   import hdu_pkg::*;

   localparam logic [1:0] BK_IDLE = 2'd0;
   localparam logic [1:0] BK_DIV  = 2'd1;
   localparam logic [1:0] BK_DAYS = 2'd2;
   localparam logic [1:0] BK_MUL  = 2'd3;

   logic [1:0]  state_ff, state_in;
   logic        ok_ff;
   logic [13:0] year_ff;
   logic [8:0]  doy_ff;
   logic [16:0] tod_ff;
   logic [6:0]  q100_ff;
   logic [21:0] base_ff;
   logic [21:0] days_ff;
   logic        out_valid_ff, out_valid_in;
   rsp_type     out_ff;

   logic        load;
   logic        finish;
   logic        out_free;
   logic [11:0] quarter;
   logic [24:0] recip_prod;
   logic [37:0] day_secs;

   assign out_free  = !out_valid_ff || rsp_pop;
   assign load      = (state_ff == BK_IDLE) && !job_empty;
   assign finish    = (state_ff == BK_MUL) && out_free;
   assign job_pop   = load;
   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_ff;

   // Year divided by four, then by a hundred through a reciprocal multiply.
   assign quarter    = year_ff[13:2];
   assign recip_prod = 25'(quarter) * 25'(RECIP_25);
   assign day_secs   = 38'(days_ff) * 38'(SECONDS_PER_DAY) + 38'(tod_ff);

   // Step sequencer.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: if (load) state_in = BK_DIV;
         BK_DIV:  state_in = BK_DAYS;
         BK_DAYS: state_in = BK_MUL;
         BK_MUL:  if (out_free) state_in = BK_IDLE;
         default: state_in = BK_IDLE;
      endcase
   end

   // The output register fills on the last step and empties when taken.
   always_comb begin
      out_valid_in = out_valid_ff;
      if (rsp_pop && out_valid_ff) out_valid_in = 1'b0;
      if (finish) out_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Arithmetic datapath; the year is shifted back for January and February.
   always_ff @(posedge clock) begin
      if (load) begin
         ok_ff   <= job_data.ok;
         year_ff <= (job_data.month <= 4'd1) ? 14'(job_data.year - 14'd1) : job_data.year;
         doy_ff  <= 9'(month_offset(job_data.month) + 9'(job_data.day) - 9'd1);
         tod_ff  <= 17'(17'(job_data.hour) * SECONDS_PER_HR + 17'(job_data.minute) * 17'd60 +
                        17'(job_data.second));
      end
      if (state_ff == BK_DIV) begin
         q100_ff <= recip_prod[RECIP_SHIFT +: 7];
         base_ff <= 22'(22'(year_ff) * DAYS_PER_YEAR + 22'(quarter) + 22'(doy_ff));
      end
      if (state_ff == BK_DAYS) begin
         days_ff <= 22'(base_ff - 22'(q100_ff) + 22'(q100_ff[6:2]) - EPOCH_SHIFT);
      end
      if (finish) begin
         out_ff.date_valid   <= ok_ff;
         out_ff.unix_seconds <= ok_ff ? day_secs : 38'd0;
      end
   end

endmodule

FILE: src/http_date_to_unix_seconds.sv
// HTTP date string to Unix seconds converter, top level.
// Channels: bytes enter through req_push/req_full with req_data holding one
// byte and its is_last marker; a word is taken on a clock edge with req_push
// high and req_full low. Results leave through rsp_empty/rsp_pop: while
// rsp_empty is low rsp_data holds the oldest result, taken on an edge with
// rsp_pop high. One result word comes out for every word marked is_last.
// The parser takes one byte per cycle while req_full is low. The converter,
// a four-step sequencer that divides by a hundred through a reciprocal
// multiply, takes no new date until the last is done; its last step waits
// while the output register still holds a result that has not been taken.
// A queue of parsed dates lies between the two; when it is full because the
// receiver stalls, req_full rises and holds off further bytes.
// Reset, synchronous and active high, returns the parser to the start of a
// string and empties the queue and the output register.
// Uses hdu_pkg, hdu_parser, hdu_queue and hdu_convert.
module http_date_to_unix_seconds #(
   parameter int unsigned QUEUE_DEPTH = hdu_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  hdu_pkg::req_type req_data,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output hdu_pkg::rsp_type rsp_data
);
   import hdu_pkg::*;

   logic    job_push;
   logic    job_full;
   job_type job_in;
   logic    job_pop;
   logic    job_empty;
   job_type job_out;

   // Byte parser.
   hdu_parser u_parser (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_full (req_full),
      .req_data (req_data),
      .job_push (job_push),
      .job_full (job_full),
      .job_data (job_in)
   );

   // Parsed date queue.
   hdu_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .full      (job_full),
      .push_data (job_in),
      .pop       (job_pop),
      .empty     (job_empty),
      .pop_data  (job_out)
   );

   // Date converter and output register.
   hdu_convert u_convert (
      .clock     (clock),
      .reset     (reset),
      .job_empty (job_empty),
      .job_pop   (job_pop),
      .job_data  (job_out),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule
